// ===== hdl/tbpd_pkg.sv =====
// shared constants, types and the arctangent table for the tilt balance drive
package tbpd_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_IDX_W       = 5;
	localparam int CORDIC_XY_W      = 27;
	localparam int CORDIC_Z_W       = 26;
	localparam int ANGLE_W          = 17;
	localparam int MUL_A_W          = 44;
	localparam int MUL_B_W          = 18;
	localparam int DIV_N_W          = 44;
	localparam int DIV_D_W          = 25;

	localparam logic signed [CORDIC_Z_W-1:0] Z_HALF_TURN = 26'sd11796480;
	localparam logic signed [MUL_A_W-1:0]    FILT_HALF   = 44'sd6717440;
	localparam logic [DIV_D_W-1:0]           FILT_DEN    = 25'd13434880;
	localparam logic [DIV_D_W-1:0]           PD_DEN      = 25'd41;
	localparam logic signed [20:0]           ANGLE_SAT   = 21'sd46080;

	localparam logic [15:0] GAIN_P_RST   = 16'd0;
	localparam logic [15:0] GAIN_D_RST   = 16'd0;
	localparam logic [15:0] BLEND_RST    = 16'd1311;
	localparam logic [14:0] OFFSET_RST   = 15'd1280;
	localparam logic [15:0] TILT_LIM_RST = 16'd11520;
	localparam logic [6:0]  DEAD_RST     = 7'd8;
	localparam logic [6:0]  DRIVE_LIM_RST = 7'd100;

	localparam logic [2:0] REG_GAIN_P    = 3'd0;
	localparam logic [2:0] REG_GAIN_D    = 3'd1;
	localparam logic [2:0] REG_BLEND     = 3'd2;
	localparam logic [2:0] REG_OFFSET    = 3'd3;
	localparam logic [2:0] REG_TILT_LIM  = 3'd4;
	localparam logic [2:0] REG_DEAD      = 3'd5;
	localparam logic [2:0] REG_DRIVE_LIM = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL1,
		ST_MUL2,
		ST_DIV1,
		ST_FILT,
		ST_MUL3,
		ST_MUL4,
		ST_DIV2,
		ST_FIN
	} state_t;

	function automatic logic [CORDIC_Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic [CORDIC_Z_W-1:0] v;
		case (idx)
			5'd0:  v = 26'd2949120;
			5'd1:  v = 26'd1740967;
			5'd2:  v = 26'd919879;
			5'd3:  v = 26'd466945;
			5'd4:  v = 26'd234379;
			5'd5:  v = 26'd117304;
			5'd6:  v = 26'd58666;
			5'd7:  v = 26'd29335;
			5'd8:  v = 26'd14668;
			5'd9:  v = 26'd7334;
			5'd10: v = 26'd3667;
			5'd11: v = 26'd1833;
			5'd12: v = 26'd917;
			5'd13: v = 26'd458;
			5'd14: v = 26'd229;
			5'd15: v = 26'd115;
			5'd16: v = 26'd57;
			5'd17: v = 26'd29;
			5'd18: v = 26'd14;
			5'd19: v = 26'd7;
			5'd20: v = 26'd4;
			5'd21: v = 26'd2;
			5'd22: v = 26'd1;
			default: v = 26'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/tbpd_cordic.sv =====
// iterative vectoring cordic, one micro-rotation per cycle, angle in 1/256 degree
module tbpd_cordic #(
	parameter int STEPS = tbpd_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [15:0]                   ay,
	input  logic signed [15:0]                   az,
	output logic                                 done,
	output logic signed [tbpd_pkg::ANGLE_W-1:0]  angle
);

	localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int XW = tbpd_pkg::CORDIC_XY_W;
	localparam int ZW = tbpd_pkg::CORDIC_Z_W;

	logic signed [XW-1:0] x_q, y_q, x0, y0, xs, ys;
	logic signed [ZW-1:0] z_q, z_rnd, step_z;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q, zero_q;

	assign x0 = XW'(az) <<< 8;
	assign y0 = XW'(ay) <<< 8;
	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign step_z = tbpd_pkg::atan_entry(tbpd_pkg::ATAN_IDX_W'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (ay == 16'sd0) && (az == 16'sd0);
			if (az < 16'sd0) begin
				x_q <= -x0;
				y_q <= -y0;
				z_q <= (ay >= 16'sd0) ? tbpd_pkg::Z_HALF_TURN : -tbpd_pkg::Z_HALF_TURN;
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_z;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_z;
			end
		end
	end

	assign z_rnd = z_q + ZW'(128);
	assign angle = zero_q ? '0 : z_rnd[tbpd_pkg::ANGLE_W+7:8];
	assign done  = done_q;

endmodule

// ===== hdl/tbpd_mul.sv =====
// bit-serial signed shift-add multiplier, product accumulated onto a start value
module tbpd_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [tbpd_pkg::MUL_A_W-1:0]  a,
	input  logic signed [tbpd_pkg::MUL_B_W-1:0]  b,
	input  logic signed [tbpd_pkg::MUL_A_W-1:0]  init,
	output logic                                 done,
	output logic signed [tbpd_pkg::MUL_A_W-1:0]  prod
);

	localparam int AW = tbpd_pkg::MUL_A_W;
	localparam int BW = tbpd_pkg::MUL_B_W;
	localparam int CW = $clog2(BW);

	logic signed [AW-1:0] acc_q, mc_q;
	logic [BW-1:0]        b_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q, last;

	assign last = (cnt_q == CW'(BW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= init;
			mc_q  <= a;
			b_q   <= b;
		end else if (busy_q) begin
			// top bit of b carries negative weight
			if (b_q[0]) begin
				acc_q <= last ? acc_q - mc_q : acc_q + mc_q;
			end
			mc_q <= mc_q <<< 1;
			b_q  <= b_q >> 1;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ===== hdl/tbpd_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module tbpd_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [tbpd_pkg::DIV_N_W-1:0]        dividend,
	input  logic [tbpd_pkg::DIV_D_W-1:0]        divisor,
	output logic                                done,
	output logic [tbpd_pkg::DIV_N_W-1:0]        quotient,
	output logic                                rem_nz
);

	localparam int NW = tbpd_pkg::DIV_N_W;
	localparam int DW = tbpd_pkg::DIV_D_W;
	localparam int CW = $clog2(NW);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q, dvs_q;
	logic [DW:0]   trial;
	logic          fits;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : DW'(trial);
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign rem_nz   = (rem_q != '0);
	assign done     = done_q;

endmodule

// ===== hdl/tilt_balance_pd_drive.sv =====
// top level: tilt estimate, complementary filter and pd drive law with config registers
// the result is formed by the cordic iterations, four serial multiplies
// and two serial divides
// one request is worked at a time; the next is taken the cycle after the result enters
// the output register, and a stalled output holds the result back from that register
// reset sets the config registers to defaults and the filter angle to zero
module tilt_balance_pd_drive #(
	parameter int CORDIC_STEPS = tbpd_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // accel_y, accel_z, gyro_x
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // motor_drive, tilt_angle, zero pad
	output logic        m_axis_tuser,   // running
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW = tbpd_pkg::MUL_A_W;
	localparam int NW = tbpd_pkg::DIV_N_W;

	tbpd_pkg::state_t state_q, state_d;

	logic signed [15:0] gain_p_q, gain_d_q, gx_q;
	logic [15:0]        blend_q, tilt_lim_q;
	logic signed [14:0] offset_q;
	logic [6:0]         dead_q, drive_lim_q;
	logic signed [16:0] filt_q;
	logic               run_q;

	logic               m_valid_q, m_run_q;
	logic signed [7:0]  m_drive_q;
	logic signed [16:0] m_angle_q;

	logic cordic_start, cordic_done, mul_start, mul_done, div_start, div_done;
	logic filt_load, out_load;

	logic signed [16:0] cordic_angle;
	logic signed [17:0] acc;
	logic signed [25:0] acc205, g640;
	logic signed [24:0] f205;
	logic signed [22:0] ang41;
	logic signed [AW-1:0] mul_a, mul_init, prod;
	logic signed [tbpd_pkg::MUL_B_W-1:0] mul_b;
	logic [NW-1:0] prod_mag, div_n, quo;
	logic [tbpd_pkg::DIV_D_W-1:0] div_d;
	logic rem_nz;

	logic signed [20:0] ang_full;
	logic signed [16:0] ang_sat;
	logic [16:0]        ang_abs;
	logic [20:0]        dmag;
	logic [6:0]         dclamp;
	logic signed [7:0]  drive;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= tbpd_pkg::GAIN_P_RST;
			gain_d_q    <= tbpd_pkg::GAIN_D_RST;
			blend_q     <= tbpd_pkg::BLEND_RST;
			offset_q    <= tbpd_pkg::OFFSET_RST;
			tilt_lim_q  <= tbpd_pkg::TILT_LIM_RST;
			dead_q      <= tbpd_pkg::DEAD_RST;
			drive_lim_q <= tbpd_pkg::DRIVE_LIM_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tbpd_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data;
				tbpd_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data;
				tbpd_pkg::REG_BLEND:     blend_q     <= cfg_data;
				tbpd_pkg::REG_OFFSET:    offset_q    <= cfg_data[14:0];
				tbpd_pkg::REG_TILT_LIM:  tilt_lim_q  <= cfg_data;
				tbpd_pkg::REG_DEAD:      dead_q      <= cfg_data[6:0];
				tbpd_pkg::REG_DRIVE_LIM: drive_lim_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tbpd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tbpd_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = tbpd_pkg::ST_CORDIC;
			tbpd_pkg::ST_CORDIC: if (cordic_done) state_d = tbpd_pkg::ST_MUL1;
			tbpd_pkg::ST_MUL1:   if (mul_done) state_d = tbpd_pkg::ST_MUL2;
			tbpd_pkg::ST_MUL2:   if (mul_done) state_d = tbpd_pkg::ST_DIV1;
			tbpd_pkg::ST_DIV1:   if (div_done) state_d = tbpd_pkg::ST_FILT;
			tbpd_pkg::ST_FILT:   state_d = tbpd_pkg::ST_MUL3;
			tbpd_pkg::ST_MUL3:   if (mul_done) state_d = tbpd_pkg::ST_MUL4;
			tbpd_pkg::ST_MUL4:   if (mul_done) state_d = tbpd_pkg::ST_DIV2;
			tbpd_pkg::ST_DIV2:   if (div_done) state_d = tbpd_pkg::ST_FIN;
			tbpd_pkg::ST_FIN:    if (!m_valid_q || m_axis_tready) state_d = tbpd_pkg::ST_IDLE;
			default:             state_d = tbpd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = (state_q == tbpd_pkg::ST_IDLE);
		cordic_start  = (state_q == tbpd_pkg::ST_IDLE) && s_axis_tvalid;
		mul_start     = ((state_q == tbpd_pkg::ST_CORDIC) && cordic_done)
			|| ((state_q == tbpd_pkg::ST_MUL1) && mul_done)
			|| (state_q == tbpd_pkg::ST_FILT)
			|| ((state_q == tbpd_pkg::ST_MUL3) && mul_done);
		div_start     = ((state_q == tbpd_pkg::ST_MUL2) || (state_q == tbpd_pkg::ST_MUL4))
			&& mul_done;
		filt_load     = (state_q == tbpd_pkg::ST_FILT);
		out_load      = (state_q == tbpd_pkg::ST_FIN) && (!m_valid_q || m_axis_tready);
	end

	tbpd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.ay     (s_axis_tdata[15:0]),
		.az     (s_axis_tdata[31:16]),
		.done   (cordic_done),
		.angle  (cordic_angle)
	);

	always_ff @(posedge clk) begin
		if (cordic_start) begin
			gx_q <= s_axis_tdata[47:32];
		end
	end

	// operands of the four products
	assign acc    = -18'(cordic_angle) - 18'(offset_q);
	assign acc205 = 26'(acc) * 26'sd205;
	assign f205   = 25'(filt_q) * 25'sd205 - (25'(gx_q) <<< 5);
	assign ang41  = 23'(ang_sat) * 23'sd41;
	assign g640   = 26'(gx_q) * 26'sd640;

	always_comb begin
		case (state_q)
			tbpd_pkg::ST_CORDIC: begin
				mul_a    = AW'(acc205);
				mul_b    = 18'(blend_q);
				mul_init = tbpd_pkg::FILT_HALF;
			end
			tbpd_pkg::ST_MUL1: begin
				mul_a    = AW'(f205);
				mul_b    = 18'(18'd65536 - 18'(blend_q));
				mul_init = prod;
			end
			tbpd_pkg::ST_FILT: begin
				mul_a    = AW'(ang41);
				mul_b    = 18'(gain_p_q);
				mul_init = '0;
			end
			default: begin
				mul_a    = AW'(g640);
				mul_b    = 18'(gain_d_q);
				mul_init = prod;
			end
		endcase
	end

	tbpd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.init   (mul_init),
		.done   (mul_done),
		.prod   (prod)
	);

	assign prod_mag = prod[AW-1] ? NW'(-prod) : NW'(prod);
	assign div_n    = (state_q == tbpd_pkg::ST_MUL2) ? prod_mag : (prod_mag >> 16);
	assign div_d    = (state_q == tbpd_pkg::ST_MUL2) ? tbpd_pkg::FILT_DEN : tbpd_pkg::PD_DEN;

	tbpd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (quo),
		.rem_nz   (rem_nz)
	);

	// floor division and saturation of the filter result
	always_comb begin
		if (prod[AW-1]) begin
			ang_full = -(21'(quo[18:0]) + 21'(rem_nz));
		end else begin
			ang_full = 21'(quo[18:0]);
		end
		if (ang_full > tbpd_pkg::ANGLE_SAT) begin
			ang_sat = 17'(tbpd_pkg::ANGLE_SAT);
		end else if (ang_full < -tbpd_pkg::ANGLE_SAT) begin
			ang_sat = 17'(-tbpd_pkg::ANGLE_SAT);
		end else begin
			ang_sat = 17'(ang_full);
		end
		ang_abs = ang_sat[16] ? 17'(-ang_sat) : 17'(ang_sat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q <= '0;
		end else if (filt_load) begin
			filt_q <= ang_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (filt_load) begin
			run_q <= (ang_abs <= 17'(tilt_lim_q));
		end
	end

	// drive sign is opposite to the pd sum
	always_comb begin
		dmag   = 21'(quo[19:0]) + 21'(dead_q);
		dclamp = (dmag > 21'(drive_lim_q)) ? drive_lim_q : dmag[6:0];
		if (!run_q || (quo[19:0] == 20'd0)) begin
			drive = '0;
		end else if (prod[AW-1]) begin
			drive = 8'(dclamp);
		end else begin
			drive = -8'(dclamp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_drive_q <= drive;
			m_run_q   <= run_q;
			m_angle_q <= filt_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_angle_q, m_drive_q};
	assign m_axis_tuser  = m_run_q;

endmodule
